### hw/rtl/adfr_pkg.sv
// ----------------------------------------------------------------------------
// adfr_pkg
// Shared constants, the command record and the header byte lookup for the
// ArtDmx packet framer.
// ----------------------------------------------------------------------------
package adfr_pkg;

    localparam int unsigned HDR_LEN    = 18;
    localparam int unsigned RESULT_CAP = 20;
    localparam int unsigned CMD_DEPTH  = 8;

    localparam logic [15:0] OP_DMX    = 16'h5000;
    localparam logic [7:0]  PROT_VER  = 8'd14;
    localparam logic [7:0]  NET_MASK  = 8'h7F;
    localparam logic [9:0]  MIN_LEN   = 10'd2;
    localparam logic [9:0]  MAX_SLOTS = 10'd512;

    // Header byte offsets
    localparam logic [4:0] HDR_OP_LO    = 5'd8;
    localparam logic [4:0] HDR_OP_HI    = 5'd9;
    localparam logic [4:0] HDR_VER_HI   = 5'd10;
    localparam logic [4:0] HDR_VER_LO   = 5'd11;
    localparam logic [4:0] HDR_SEQ      = 5'd12;
    localparam logic [4:0] HDR_PHYS     = 5'd13;
    localparam logic [4:0] HDR_SUBUNI   = 5'd14;
    localparam logic [4:0] HDR_NET      = 5'd15;
    localparam logic [4:0] HDR_LEN_HI   = 5'd16;
    localparam logic [4:0] HDR_LEN_LO   = 5'd17;

    // One step of work handed from the front to the back
    typedef struct packed {
        logic       hdr;
        logic [7:0] seq;
        logic [7:0] subuni;
        logic [6:0] net;
        logic [9:0] len;
        logic       has_slot;
        logic [7:0] slot;
        logic [4:0] pad_cnt;
        logic       ends;
    } cmd_t;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input cmd_t c);
        logic [7:0] b;
        unique case (idx)
            HDR_OP_LO:  b = OP_DMX[7:0];
            HDR_OP_HI:  b = OP_DMX[15:8];
            HDR_VER_HI: b = 8'h00;
            HDR_VER_LO: b = PROT_VER;
            HDR_SEQ:    b = c.seq;
            HDR_PHYS:   b = 8'h00;
            HDR_SUBUNI: b = c.subuni;
            HDR_NET:    b = {1'b0, c.net};
            HDR_LEN_HI: b = {6'd0, c.len[9:8]};
            HDR_LEN_LO: b = c.len[7:0];
            default:    b = (idx < HDR_OP_LO) ? id_byte(idx[2:0]) : 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/adfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// adfr_cmd_fifo
// Short command queue between the front and the back of the framer.
// ----------------------------------------------------------------------------
module adfr_cmd_fifo #(
    parameter int unsigned DEPTH = adfr_pkg::CMD_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  adfr_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output adfr_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    adfr_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

### hw/rtl/adfr_front.sv
// ----------------------------------------------------------------------------
// adfr_front
// Accepts slot transactions, tracks frame state and turns each one into a
// command: header when a frame opens, slot byte and a number of zero pad bytes.
// ----------------------------------------------------------------------------
module adfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  logic [7:0]     slot_value,
    input  logic [15:0]    universe_id,
    input  logic [9:0]     slot_count,
    input  logic           last_slot,
    output logic           wr_en,
    output adfr_pkg::cmd_t wr_data
);

    logic       in_frame_reg, in_frame_next;
    logic       pad_reg, pad_next;
    logic [7:0] seq_reg, seq_next;
    logic [9:0] len_reg, len_next;
    logic [9:0] sent_reg, sent_next;

    logic       accept;
    logic       is_new;
    logic [9:0] clamp_len;
    logic [9:0] len_eff;
    logic [9:0] sent_b;
    logic [7:0] seq_inc;
    logic       slot_emit;
    logic       pad_req;
    logic       close;
    logic [4:0] k0;
    logic [4:0] budget;
    logic [9:0] sent1;
    logic [9:0] remain;
    logic [4:0] pad_n;
    logic [9:0] sent2;

    assign accept = push && !full;
    assign is_new = !in_frame_reg && !pad_reg;

    // Clamp to MIN_LEN..MAX_SLOTS, then round up to even
    always_comb
    begin
        clamp_len = slot_count;
        if (clamp_len > adfr_pkg::MAX_SLOTS)
        begin
            clamp_len = adfr_pkg::MAX_SLOTS;
        end
        if (clamp_len < adfr_pkg::MIN_LEN)
        begin
            clamp_len = adfr_pkg::MIN_LEN;
        end
        if (clamp_len[0])
        begin
            clamp_len = clamp_len + 10'd1;
        end
    end

    assign seq_inc = (seq_reg == 8'hFF) ? 8'd1 : seq_reg + 8'd1;

    always_comb
    begin
        len_eff   = is_new ? clamp_len : len_reg;
        sent_b    = is_new ? 10'd0 : sent_reg;
        slot_emit = !pad_reg && (is_new ? (slot_count != 10'd0) : (sent_reg < len_reg));
        pad_req   = pad_reg || last_slot || (is_new && slot_count == 10'd0);
        close     = pad_reg || last_slot;
        k0        = (is_new ? 5'(adfr_pkg::HDR_LEN) : 5'd0) + {4'd0, slot_emit};
        budget    = 5'(adfr_pkg::RESULT_CAP) - k0;
        sent1     = sent_b + {9'd0, slot_emit};
        remain    = len_eff - sent1;
        pad_n     = 5'd0;
        if (pad_req)
        begin
            pad_n = (remain > {5'd0, budget}) ? budget : remain[4:0];
        end
        sent2 = sent1 + {5'd0, pad_n};
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pad_next      = pad_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        sent_next     = sent_reg;
        if (accept)
        begin
            sent_next = sent2;
            if (is_new)
            begin
                seq_next      = seq_inc;
                len_next      = clamp_len;
                in_frame_next = 1'b1;
            end
            if (close)
            begin
                if (sent2 >= len_eff)
                begin
                    in_frame_next = 1'b0;
                    pad_next      = 1'b0;
                end
                else
                begin
                    pad_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pad_reg      <= 1'b0;
            seq_reg      <= '0;
            len_reg      <= '0;
            sent_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pad_reg      <= pad_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            sent_reg     <= sent_next;
        end
    end

    // Drop transactions that produce no bytes
    assign wr_en = accept && (is_new || slot_emit || pad_n != 5'd0);

    always_comb
    begin
        wr_data          = '0;
        wr_data.hdr      = is_new;
        wr_data.seq      = seq_inc;
        wr_data.subuni   = universe_id[7:0];
        wr_data.net      = universe_id[14:8] & adfr_pkg::NET_MASK[6:0];
        wr_data.len      = clamp_len;
        wr_data.has_slot = slot_emit;
        wr_data.slot     = slot_value;
        wr_data.pad_cnt  = pad_n;
        wr_data.ends     = (sent2 == len_eff) && (sent_b < len_eff);
    end

`ifndef NO_ASSERTIONS
    a_pad_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> in_frame_reg)
        else $error("padding outside a frame");

    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg <= len_reg)
        else $error("payload count past frame length");

    a_len_even: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (len_reg[0] == 1'b0 && len_reg >= adfr_pkg::MIN_LEN))
        else $error("frame length not even or too short");
`endif

endmodule

### hw/rtl/adfr_back.sv
// ----------------------------------------------------------------------------
// adfr_back
// Expands queued commands into packet bytes, one per cycle while the output
// register that the consumer drains is empty or being popped.
// ----------------------------------------------------------------------------
module adfr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  adfr_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_rd,
    output logic [7:0]     out_byte,
    output logic           last_byte,
    output logic           empty,
    input  logic           pop
);

    logic [4:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       advance;
    logic [4:0] total;
    logic [4:0] rel;
    logic       at_end;
    logic [7:0] cur_byte;

    assign total   = (cmd.hdr ? 5'(adfr_pkg::HDR_LEN) : 5'd0)
                   + {4'd0, cmd.has_slot} + cmd.pad_cnt;
    assign rel     = pos_reg - (cmd.hdr ? 5'(adfr_pkg::HDR_LEN) : 5'd0);
    assign at_end  = (pos_reg == total - 5'd1);
    assign advance = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_rd  = advance && at_end;

    always_comb
    begin
        if (cmd.hdr && pos_reg < 5'(adfr_pkg::HDR_LEN))
        begin
            cur_byte = adfr_pkg::hdr_byte(pos_reg, cmd);
        end
        else if (cmd.has_slot && rel == 5'd0)
        begin
            cur_byte = cmd.slot;
        end
        else
        begin
            cur_byte = 8'h00;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            pos_next       = at_end ? 5'd0 : pos_reg + 5'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= cmd.ends && at_end;
        end
    end

    assign out_byte  = byte_reg;
    assign last_byte = last_reg;
    assign empty     = !out_valid_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_empty |-> pos_reg < total)
        else $error("byte position past end of command");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_empty |-> pos_reg == 5'd0)
        else $error("byte position held with no command");
`endif

endmodule

### hw/rtl/artdmx_packet_framer_top.sv
// ----------------------------------------------------------------------------
// artdmx_packet_framer_top
// ArtDmx packet framer: slot transactions in, packet bytes out in wire order.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | push / full        | slot_value, universe_id, slot_count,
//            |                    | last_slot
//   output   | pop / empty        | out_byte, last_byte
//
// One input transaction per cycle while the command queue has room; each
// becomes one queue entry (none if it yields no bytes).
// The back emits one byte per cycle while its output register is empty or
// popped, so a frame's first slot costs 18 header bytes plus its payload
// and pad bytes; the queue absorbs that burst. Reset clears frame state,
// sequence number, queue and output register. full rises only when the command
// queue is full; a held output byte stalls the back alone while pop is low.
// ----------------------------------------------------------------------------
module artdmx_packet_framer_top #(
    parameter int unsigned CMD_DEPTH = adfr_pkg::CMD_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  slot_value,
    input  logic [15:0] universe_id,
    input  logic [9:0]  slot_count,
    input  logic        last_slot,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    adfr_pkg::cmd_t wr_data;
    adfr_pkg::cmd_t rd_data;
    logic           wr_en;
    logic           rd_en;
    logic           cmd_empty;

    adfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .slot_value  (slot_value),
        .universe_id (universe_id),
        .slot_count  (slot_count),
        .last_slot   (last_slot),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    adfr_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .full    (full),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .empty   (cmd_empty)
    );

    adfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rd_data),
        .cmd_empty (cmd_empty),
        .cmd_rd    (rd_en),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ArtDmx packet framer. Slot transactions are
// queued up front and fed through push/full with random gaps; packet bytes
// are drained through pop/empty with random stalls. Each accepted slot is run
// through a local framer model, and every popped byte is compared with the
// oldest predicted byte.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [63:0] ART_ID         = 64'h4172_742D_4E65_7400;
    localparam int          TOTAL_ITEMS    = 380;
    localparam int          WRAP_FRAMES    = 256;
    localparam int          TAIL_ITEMS     = 60;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic       open;
        logic       pad;
        logic [7:0] seq;
        logic [9:0] len;
        logic [9:0] sent;
    } framer_state_t;

    typedef struct packed {
        logic [7:0]  slot;
        logic [15:0] uni;
        logic [9:0]  count;
        logic        last;
    } slot_item_t;

    // One entry per byte: {last_byte, out_byte}
    typedef logic [adfr_pkg::RESULT_CAP-1:0][8:0] pkt_bytes_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  slot_value = '0;
    logic [15:0] universe_id = '0;
    logic [9:0]  slot_count = '0;
    logic        last_slot = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        last_byte;

    slot_item_t    pending_slots[$];
    logic [8:0]    expected_bytes[$];
    slot_item_t    on_port = '0;
    framer_state_t framer = '0;

    int  items_total    = 0;
    int  items_accepted = 0;
    int  frames_opened  = 0;
    int  pad_runs       = 0;
    int  bytes_checked  = 0;
    int  mismatches     = 0;
    int  in_wait        = 0;
    int  out_wait       = 0;
    int  in_rate        = 0;
    int  out_rate       = 0;
    int  in_cycles      = 0;
    int  out_cycles     = 0;
    int  quiet_cycles   = 0;
    logic no_idle       = 1'b0;

    artdmx_packet_framer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .slot_value  (slot_value),
        .universe_id (universe_id),
        .slot_count  (slot_count),
        .last_slot   (last_slot),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    always #2 clk = ~clk;

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return 10;
            default: return 35;
        endcase
    endfunction

    function automatic void send_slot(inout framer_state_t st, inout pkt_bytes_t outs,
                                      inout int k, input logic [7:0] b);
        st.sent = st.sent + 10'd1;
        outs[k] = {st.sent == st.len, b};
        k++;
    endfunction

    // Emit owed zeros within the per-transaction budget; true once the packet is whole.
    function automatic logic pad_zeros(inout framer_state_t st, inout pkt_bytes_t outs,
                                       inout int k);
        while (st.sent < st.len && k < int'(adfr_pkg::RESULT_CAP))
            send_slot(st, outs, k, 8'h00);
        return st.sent >= st.len;
    endfunction

    function automatic int frame_bytes(inout framer_state_t st, input slot_item_t it,
                                       output pkt_bytes_t outs);
        int         k;
        int         n;
        logic [7:0] hb [0:adfr_pkg::HDR_LEN-1];
        k = 0;
        outs = '0;
        if (st.pad)
        begin
            if (pad_zeros(st, outs, k))
            begin
                st.pad = 1'b0;
                st.open = 1'b0;
            end
            return k;
        end
        if (!st.open)
        begin
            n = int'(it.count);
            if (n > int'(adfr_pkg::MAX_SLOTS))
                n = int'(adfr_pkg::MAX_SLOTS);
            if (n < int'(adfr_pkg::MIN_LEN))
                n = int'(adfr_pkg::MIN_LEN);
            if (n % 2 != 0)
                n++;
            st.len = 10'(n);
            st.sent = '0;
            st.open = 1'b1;
            st.seq = st.seq + 8'd1;
            if (st.seq == 8'd0)
                st.seq = 8'd1;
            for (int i = 0; i < 8; i++)
                hb[i] = ART_ID[63 - 8 * i -: 8];
            hb[8]  = adfr_pkg::OP_DMX[7:0];
            hb[9]  = adfr_pkg::OP_DMX[15:8];
            hb[10] = 8'h00;
            hb[11] = adfr_pkg::PROT_VER;
            hb[12] = st.seq;
            hb[13] = 8'h00;
            hb[14] = it.uni[7:0];
            hb[15] = it.uni[15:8] & adfr_pkg::NET_MASK;
            hb[16] = {6'd0, st.len[9:8]};
            hb[17] = st.len[7:0];
            for (int i = 0; i < int'(adfr_pkg::HDR_LEN); i++)
            begin
                outs[k] = {1'b0, hb[i]};
                k++;
            end
            if (it.count == '0)
                void'(pad_zeros(st, outs, k));
            else
                send_slot(st, outs, k, it.slot);
        end
        else if (st.sent < st.len)
        begin
            send_slot(st, outs, k, it.slot);
        end
        if (it.last)
        begin
            if (pad_zeros(st, outs, k))
                st.open = 1'b0;
            else
                st.pad = 1'b1;
        end
        return k;
    endfunction

    task automatic queue_item(input logic [7:0] s, input logic [15:0] u,
                              input logic [9:0] c, input logic l);
        slot_item_t it;
        it = {s, u, c, l};
        pending_slots.push_back(it);
        items_total++;
    endtask

    // Driver: present pending slots, predict each accepted transaction
    always @(posedge clk)
    begin
        pkt_bytes_t step_out;
        int         nres;
        logic       was_pad;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (!framer.open)
                    frames_opened++;
                was_pad = framer.pad;
                nres = frame_bytes(framer, on_port, step_out);
                if (framer.pad && !was_pad)
                    pad_runs++;
                for (int k = 0; k < nres; k++)
                    expected_bytes.push_back(step_out[k]);
                items_accepted++;
            end
            if (in_cycles % 64 == 0)
                in_rate = pick_rate();
            in_cycles++;
            // Hold the transaction while full is high
            if (!(push && full))
            begin
                if (in_wait > 0)
                begin
                    in_wait--;
                    push <= 1'b0;
                end
                else if (pending_slots.size() != 0 && !no_idle
                         && $urandom_range(0, 99) < in_rate)
                begin
                    in_wait = int'($urandom_range(0, 10));
                    push <= 1'b0;
                end
                else if (pending_slots.size() != 0)
                begin
                    on_port = pending_slots.pop_front();
                    push <= 1'b1;
                    slot_value <= on_port.slot;
                    universe_id <= on_port.uni;
                    slot_count <= on_port.count;
                    last_slot <= on_port.last;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
            no_idle <= pending_slots.size() < TAIL_ITEMS;
        end
    end

    // Monitor: drain bytes with random stalls, compare against predictions
    always @(posedge clk)
    begin
        logic [8:0] want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected byte %02h last %0b", $time, out_byte, last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want[7:0])
                    begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, want[7:0], out_byte);
                    end
                    if (last_byte !== want[8])
                    begin
                        mismatches++;
                        $display("%0t: last_byte expected %0b, actual %0b",
                                 $time, want[8], last_byte);
                    end
                end
            end
            if (out_cycles % 80 == 0)
                out_rate = pick_rate();
            out_cycles++;
            if (out_wait > 0)
            begin
                out_wait--;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < out_rate)
            begin
                out_wait = int'($urandom_range(0, 10));
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int          kind;
        int          cnt;
        int          n;
        logic [15:0] u;

        // Zero declared slots: header then two zeros, done in one step
        queue_item(8'hFF, 16'h0000, 10'd0, 1'b1);
        // Zero slots with the frame held open; later slots drop until last
        queue_item(8'hAA, 16'hFFFF, 10'd0, 1'b0);
        queue_item(8'h55, 16'hFFFF, 10'd0, 1'b0);
        queue_item(8'h01, 16'hFFFF, 10'd0, 1'b1);
        // One slot clamps up to two, pad the second
        queue_item(8'h00, 16'h00FF, 10'd1, 1'b1);
        // Odd count rounds up to even
        queue_item(8'hFF, 16'h7F00, 10'd3, 1'b0);
        queue_item(8'h01, 16'h7F00, 10'd3, 1'b0);
        queue_item(8'h80, 16'h7F00, 10'd3, 1'b1);
        // Slots beyond length are dropped
        queue_item(8'h11, 16'h8000, 10'd2, 1'b0);
        queue_item(8'h22, 16'h8000, 10'd2, 1'b0);
        queue_item(8'h33, 16'h8000, 10'd2, 1'b0);
        queue_item(8'h44, 16'h8000, 10'd2, 1'b1);
        // Early last slot; padding eats the next two transactions
        queue_item(8'h7E, 16'h1234, 10'd40, 1'b1);
        queue_item(8'hFF, 16'hFFFF, 10'h3FF, 1'b1);
        queue_item(8'hFF, 16'hFFFF, 10'h3FF, 1'b1);
        for (int i = 0; i < 5; i++)
            queue_item(8'(i), 16'h7F7F, 10'd5, i == 4);

        // Enough one-step packets to wrap the sequence number
        for (int i = 0; i < WRAP_FRAMES; i++)
            queue_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       10'($urandom_range(0, 2)), 1'b1);

        while (items_total < TOTAL_ITEMS)
        begin
            kind = int'($urandom_range(0, 99));
            u = 16'($urandom_range(0, 65535));
            if (kind < 25)
            begin
                queue_item(8'($urandom_range(0, 255)), u, 10'($urandom_range(0, 3)), 1'b1);
            end
            else if (kind < 65)
            begin
                cnt = int'($urandom_range(1, 20));
                for (int i = 0; i < cnt; i++)
                    queue_item(8'($urandom_range(0, 255)), u, 10'(cnt), i == cnt - 1);
            end
            else if (kind < 77)
            begin
                cnt = int'($urandom_range(4, 40));
                n = int'($urandom_range(1, cnt - 1));
                for (int i = 0; i < n; i++)
                    queue_item(8'($urandom_range(0, 255)), u, 10'(cnt), i == n - 1);
            end
            else if (kind < 87)
            begin
                cnt = int'($urandom_range(1, 12));
                n = cnt + int'($urandom_range(1, 6));
                for (int i = 0; i < n; i++)
                    queue_item(8'($urandom_range(0, 255)), u, 10'(cnt), i == n - 1);
            end
            else if (kind < 91)
            begin
                cnt = int'($urandom_range(0, 1023));
                n = int'($urandom_range(1, 3));
                for (int i = 0; i < n; i++)
                    queue_item(8'($urandom_range(0, 255)), u, 10'(cnt), i == n - 1);
            end
            else if (kind < 95)
            begin
                n = int'($urandom_range(1, 3));
                for (int i = 0; i < n; i++)
                    queue_item(8'($urandom_range(0, 255)), u, 10'd0, i == n - 1);
            end
            else
            begin
                n = int'($urandom_range(1, 4));
                for (int i = 0; i < n; i++)
                    queue_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!(items_accepted == items_total && expected_bytes.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bytes.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d predicted bytes never arrived", $time, expected_bytes.size());
        end
        $display("%0d slot transactions over %0d frames, %0d of them padded across steps",
                 items_accepted, frames_opened, pad_runs);
        $display("%0d packet bytes compared, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
